### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on i_clk, off during reset.
`define CHECK_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/vsdm_pkg.sv
`default_nettype none
package vsdm_pkg;

    localparam int QUEUE_WIDTH = 16;
    localparam int RES_MAX     = 6;

    localparam logic [7:0] OP_WAIT_N   = 8'h70;
    localparam logic [7:0] OP_WAIT_ARG = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL = 8'h63;
    localparam logic [7:0] OP_END      = 8'h66;
    localparam logic [7:0] OP_DATA     = 8'h67;
    localparam logic [3:0] NIB_WAIT    = 4'h7;
    localparam logic [3:0] NIB_COUNT   = 4'h8;
    localparam logic [15:0] NTSC_FRAME = 16'd735;
    localparam logic [15:0] PAL_FRAME  = 16'd882;
    localparam logic [15:0] CHUNK_MAX  = 16'hFFFF;
    localparam logic [15:0] SHORT_MAX  = 16'h0010;
    localparam logic [3:0]  CNT_SAT    = 4'hF;

    localparam logic [1:0] REG_MAX_SMALL = 2'd0;
    localparam logic [1:0] REG_LOOP_EN   = 2'd1;
    localparam logic [1:0] REG_LOOP_OFS  = 2'd2;

    typedef logic [7:0] t_byte;
    typedef t_byte t_res_buf [RES_MAX];

    // Length of a wait chunk (0, 1 or 3 bytes) in [25:24], bytes first-out in [7:0].
    typedef struct packed {
        logic [1:0]  len;
        logic [23:0] bytes;
    } t_seg;

    function automatic t_seg chunk_enc(input logic [15:0] v);
        t_seg s;
        s.len = 2'd0;
        s.bytes = 24'd0;
        if (v == 16'd0) begin
            s.len = 2'd0;
        end else if (v <= SHORT_MAX) begin
            s.len = 2'd1;
            s.bytes = {16'd0, OP_WAIT_N | {4'd0, 4'(v - 16'd1)}};
        end else begin
            s.len = 2'd3;
            s.bytes = {v[15:8], v[7:0], OP_WAIT_ARG};
        end
        return s;
    endfunction

    function automatic logic [3:0] cmd_len(input logic [7:0] op);
        logic [3:0] n;
        case (op)
            8'h50, 8'h94:        n = 4'd2;
            8'h61:               n = 4'd3;
            8'h62, 8'h63, 8'h66: n = 4'd1;
            8'h68:               n = 4'd12;
            8'h90, 8'h91, 8'h95: n = 4'd5;
            8'h92:               n = 4'd6;
            8'h93:               n = 4'd11;
            default: begin
                case (op[7:4])
                    4'h3, 4'h4:        n = 4'd2;
                    4'h5, 4'hA, 4'hB:  n = 4'd3;
                    4'hC, 4'hD:        n = 4'd4;
                    4'hE, 4'hF:        n = 4'd5;
                    default:           n = 4'd1;
                endcase
            end
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

### design/vgm_small_delay_merger_core.sv
// Channel | direction | handshake               | payload
// in      | to core   | i_in_valid / o_in_stall  | i_in_byte
// out     | from core | o_out_valid / i_out_stall| o_out_byte, o_run_last, o_loop_mark,
//         |           |                          | o_end_seen, o_total_samples, o_changed_any
// cfg     | to core   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// The command decode is combinational and loads a six-byte result buffer,
// taking one input byte per cycle unless stalled. The buffer drains one
// transaction per cycle unless the output stalls; a byte giving n results
// holds the input until the last one leaves, as the next byte enters with
// it, so pass-through bytes flow at one per cycle without output stalls.
// Input stalls while non-last results wait or the last meets an output stall.
// Reset (sync, active low) sets all state but the buffer bytes and total; cfg is always ready.
`default_nettype none
`include "assert_macros.svh"
module vgm_small_delay_merger_core import vsdm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_loop_mark,
    output logic             o_end_seen,
    output logic [31:0]      o_total_samples,
    output logic             o_changed_any,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // configuration
    logic [15:0] r_max_small;
    logic        r_loop_en;
    logic [31:0] r_loop_ofs;

    // parser state
    logic [31:0] r_pos, n_pos;
    logic [7:0]  r_op, n_op;
    logic [3:0]  r_bic, n_bic;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_darg, n_darg;
    logic [QUEUE_WIDTH-1:0] r_held, n_held;
    logic        r_pwd, n_pwd;
    logic [31:0] r_samp, n_samp;
    logic        r_stop, n_stop;
    logic        r_merged, n_merged;
    logic        r_lh, n_lh;

    // result buffer
    t_res_buf    r_buf, n_buf;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_idx;
    logic        r_loop, n_loop;
    logic        r_end, n_end;
    logic [31:0] r_total, n_total;

    logic in_acc, out_acc, last;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_idx < r_cnt);
    assign last        = (r_idx == r_cnt - 3'd1);
    assign out_acc     = o_out_valid && !i_out_stall;
    // take the next byte once the buffer is empty or its last byte leaves now
    assign o_in_stall  = o_out_valid && !(last && out_acc);
    assign in_acc      = i_in_valid && !o_in_stall;

    assign o_out_byte      = r_buf[r_idx < 3'(RES_MAX) ? r_idx : 3'd0];
    assign o_run_last      = last;
    assign o_loop_mark     = r_loop && (r_idx == 3'd0);
    assign o_end_seen      = r_end;
    assign o_total_samples = r_end ? r_total : 32'd0;
    assign o_changed_any   = r_merged;

    always_comb begin
        logic        fin, wr, was, lh;
        logic [15:0] d;
        logic [2:0]  ncmd;
        t_byte       c0, c1, c2, pb;
        logic        put_b, put_end;
        logic [3:0]  idx;
        logic [16:0] tot;
        logic [15:0] v1, v2;
        t_seg        s1, s2;
        logic [2:0]  cnt;
        logic [7:0]  part;
        logic [QUEUE_WIDTH:0] hsum;

        n_pos = r_pos; n_op = r_op; n_bic = r_bic; n_rem = r_rem; n_darg = r_darg;
        n_held = r_held; n_pwd = r_pwd; n_samp = r_samp; n_stop = r_stop;
        n_merged = r_merged; n_lh = r_lh;
        n_buf = r_buf; n_cnt = 3'd0; n_loop = 1'b0; n_end = 1'b0; n_total = r_total;
        fin = 1'b0; wr = 1'b0; was = 1'b0; d = 16'd0; ncmd = 3'd0;
        c0 = 8'd0; c1 = 8'd0; c2 = 8'd0; pb = i_in_byte; put_b = 1'b0; put_end = 1'b0;
        idx = r_bic; tot = 17'd0; part = 8'd0; hsum = '0;
        s1 = '0; s2 = '0; v1 = 16'd0; v2 = 16'd0; cnt = 3'd0; lh = r_lh;

        if (in_acc && !r_stop) begin
            n_pos = r_pos + 32'd1;
            if (r_rem == 32'd0) begin
                n_op = i_in_byte;
                n_bic = 4'd1;
                lh = r_loop_en && (r_pos == r_loop_ofs);
                n_lh = lh;
                c0 = i_in_byte;
                ncmd = 3'd1;
                if (i_in_byte[7:4] == NIB_WAIT) begin
                    fin = 1'b1; d = {12'd0, i_in_byte[3:0]} + 16'd1;
                end else if (i_in_byte == OP_WAIT_NTSC) begin
                    fin = 1'b1; d = NTSC_FRAME;
                end else if (i_in_byte == OP_WAIT_PAL) begin
                    fin = 1'b1; d = PAL_FRAME;
                end else if (i_in_byte == OP_WAIT_ARG) begin
                    n_rem = 32'd2; n_darg = 16'd0;
                end else begin
                    n_pwd = 1'b0;
                    if (i_in_byte[7:4] == NIB_COUNT)
                        n_samp = r_samp + {28'd0, i_in_byte[3:0]};
                    put_b = 1'b1;
                    if (i_in_byte == OP_END) begin
                        n_stop = 1'b1; put_end = 1'b1;
                    end else if (i_in_byte == OP_DATA) begin
                        n_rem = 32'd6;
                    end else begin
                        n_rem = {28'd0, cmd_len(i_in_byte) - 4'd1};
                    end
                end
            end else begin
                n_rem = r_rem - 32'd1;
                if (r_bic < CNT_SAT) n_bic = r_bic + 4'd1;
                if (r_op == OP_WAIT_ARG) begin
                    if (idx == 4'd1) n_darg = {8'd0, i_in_byte};
                    else n_darg = {i_in_byte, r_darg[7:0]};
                    if (n_rem == 32'd0) begin
                        fin = 1'b1; d = n_darg; ncmd = 3'd3;
                        c0 = OP_WAIT_ARG; c1 = n_darg[7:0]; c2 = n_darg[15:8];
                    end
                end else begin
                    if (r_op == OP_DATA && idx >= 4'd3 && idx <= 4'd6) begin
                        part = (idx == 4'd6) ? {1'b0, i_in_byte[6:0]} : i_in_byte;
                        case (idx)
                            4'd3:    n_rem = n_rem + {24'd0, part};
                            4'd4:    n_rem = n_rem + {16'd0, part, 8'd0};
                            4'd5:    n_rem = n_rem + {8'd0, part, 16'd0};
                            default: n_rem = n_rem + {part, 24'd0};
                        endcase
                    end
                    n_lh = 1'b0; lh = 1'b0;
                    put_b = 1'b1;
                end
            end

            if (fin) begin
                was = r_pwd || lh;
                n_pwd = 1'b1;
                n_samp = r_samp + {16'd0, d};
                if (r_held == '0 && d > r_max_small) begin
                    wr = 1'b1;
                end else if (d <= r_max_small && !was) begin
                    hsum = {1'b0, r_held} + (QUEUE_WIDTH+1)'(d);
                    n_held = hsum > (QUEUE_WIDTH+1)'(CHUNK_MAX) ?
                             QUEUE_WIDTH'(CHUNK_MAX) : hsum[QUEUE_WIDTH-1:0];
                    n_merged = 1'b1;
                end else begin
                    tot = 17'(r_held) + (was ? 17'd0 : {1'b0, d});
                    wr = was;
                    n_held = '0;
                end
            end

            // assemble the results in order: chunk, chunk, command / passed byte
            v1 = tot[16] ? CHUNK_MAX : tot[15:0];
            v2 = 16'(tot - {1'b0, v1});
            s1 = chunk_enc(v1);
            s2 = chunk_enc(v2);
            for (int j = 0; j < 3; j++) begin
                if (2'(j) < s1.len) begin
                    n_buf[cnt] = s1.bytes[8*j +: 8]; cnt = cnt + 3'd1;
                end
            end
            for (int j = 0; j < 3; j++) begin
                if (2'(j) < s2.len) begin
                    n_buf[cnt] = s2.bytes[8*j +: 8]; cnt = cnt + 3'd1;
                end
            end
            if (wr) begin
                n_buf[cnt] = c0; cnt = cnt + 3'd1;
                if (ncmd == 3'd3) begin
                    n_buf[cnt] = c1; cnt = cnt + 3'd1;
                    n_buf[cnt] = c2; cnt = cnt + 3'd1;
                end
            end
            if (put_b) begin
                n_buf[cnt] = pb; cnt = cnt + 3'd1;
            end
            n_cnt = cnt;
            n_loop = lh;
            n_end = put_end;
            n_total = r_samp - 32'(r_held);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_small <= 16'd1;
            r_loop_en <= 1'b0;
            r_loop_ofs <= 32'd0;
            r_pos <= '0; r_op <= '0; r_bic <= '0; r_rem <= '0; r_darg <= '0;
            r_held <= '0; r_pwd <= 1'b0; r_samp <= '0; r_stop <= 1'b0;
            r_merged <= 1'b0; r_lh <= 1'b0;
            r_cnt <= 3'd0; r_idx <= 3'd0; r_loop <= 1'b0; r_end <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MAX_SMALL: r_max_small <= i_cfg_data[15:0];
                    REG_LOOP_EN:   r_loop_en <= i_cfg_data[0];
                    REG_LOOP_OFS:  r_loop_ofs <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos <= n_pos; r_op <= n_op; r_bic <= n_bic; r_rem <= n_rem;
            r_darg <= n_darg; r_held <= n_held; r_pwd <= n_pwd; r_samp <= n_samp;
            r_stop <= n_stop; r_merged <= n_merged; r_lh <= n_lh;
            if (in_acc) begin
                r_cnt <= n_cnt; r_idx <= 3'd0; r_loop <= n_loop; r_end <= n_end;
            end else if (out_acc) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_buf <= n_buf;
            r_total <= n_total;
        end
    end

    `CHECK_CLK(a_cnt_bound, (r_cnt <= 3'(RES_MAX)), "result count above six")
    `CHECK_CLK(a_hold_in, (o_out_valid && !last) |-> o_in_stall,
        "input taken while results pending")
    `CHECK_CLK(a_end_single, o_end_seen |-> (r_cnt == 3'd1 && r_stop),
        "end result not alone")
    `CHECK_CLK(a_stop_sticky, r_stop |=> r_stop, "stream restarted without reset")

endmodule
`default_nettype wire
